// ===== sv/cmad_pkg.sv =====
// ----------------------------------------------------------------------------
// Centered moving average detrend: shared definitions
// Register indexes, fixed widths and the control word that travels with
// each item through the pipeline.
// ----------------------------------------------------------------------------
package cmad_pkg;

   localparam int HW_BITS    = 6;
   localparam int INV_BITS   = 24;
   localparam int RING_AW    = 7;
   localparam int RING_DEPTH = 1 << RING_AW;
   localparam int SEEN_BITS  = 8;
   localparam int SEEN_MAX   = 255;

   typedef enum logic [0:0] {
      CSR_HALF_WINDOW    = 1'b0,
      CSR_INV_WINDOW_LEN = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic               sub_old;
      logic               has_result;
      logic               has_window;
      logic               eos;
      logic [HW_BITS-1:0] pending;
   } ctl_type;

endpackage

// ===== sv/cmad_emit.sv =====
// ----------------------------------------------------------------------------
// Centered moving average detrend: result emitter
// Output register that shows the normal result of an item and then counts
// out the zero results that flush the end of a stream.
// ----------------------------------------------------------------------------
module cmad_emit
   import cmad_pkg::*;
#(
   parameter int SAMPLE_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  ctl_type                load_ctl,
   input  logic [SAMPLE_BITS-1:0] load_a,
   input  logic [SAMPLE_BITS-1:0] load_b,
   output logic                   free,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // Fields from bit 0 up: detrended_a, detrended_b, zero padding.
   output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata,
   // Fields from bit 0 up: has_window.
   output logic                   rsp_tuser,
   output logic                   rsp_tlast
);

   localparam int TDATA_BITS = ((2*SAMPLE_BITS+7)/8)*8;

   logic                   valid_ff;
   logic                   normal_ff;
   logic                   win_ff;
   logic [HW_BITS-1:0]     pend_ff;
   logic [SAMPLE_BITS-1:0] a_ff;
   logic [SAMPLE_BITS-1:0] b_ff;
   logic                   final_item;
   logic                   fire;

   assign final_item = normal_ff ? (pend_ff == '0) : (pend_ff == HW_BITS'(1));
   assign fire       = valid_ff && rsp_tready;
   assign free       = !valid_ff || (rsp_tready && final_item);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         normal_ff <= 1'b0;
         pend_ff   <= '0;
      end else if (load) begin
         valid_ff  <= 1'b1;
         normal_ff <= load_ctl.has_result;
         pend_ff   <= load_ctl.eos ? load_ctl.pending : '0;
      end else if (fire) begin
         if (final_item) begin
            valid_ff <= 1'b0;
         end else if (normal_ff) begin
            normal_ff <= 1'b0;
         end else begin
            pend_ff <= pend_ff - HW_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         win_ff <= load_ctl.has_window;
         a_ff   <= load_ctl.has_window ? load_a : '0;
         b_ff   <= load_ctl.has_window ? load_b : '0;
      end
   end

   always_comb begin
      rsp_tvalid = valid_ff;
      if (normal_ff) begin
         rsp_tdata = TDATA_BITS'({b_ff, a_ff});
         rsp_tuser = win_ff;
         rsp_tlast = 1'b0;
      end else begin
         rsp_tdata = '0;
         rsp_tuser = 1'b0;
         rsp_tlast = (pend_ff == HW_BITS'(1));
      end
   end

   a_last_is_edge: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> !rsp_tuser)
      else $error("final result of a stream carries a window");

   a_edge_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("edge result is not zero");

   a_flush_count: assert property (@(posedge clock) disable iff (reset)
      (fire && !normal_ff && (pend_ff > HW_BITS'(1))) |=>
      (valid_ff && (pend_ff == $past(pend_ff) - HW_BITS'(1))))
      else $error("flush count did not step down");

endmodule

// ===== sv/centered_moving_average_detrend_core.sv =====
// ----------------------------------------------------------------------------
// Centered moving average detrend core
// Results pass through stage 1, stage 2, stage 3 and the emitter register
// on their way to rsp. Throughput: one item per cycle while rsp is not
// stalled; the ring memory is written once and read at two addresses per
// item, and the running sums close their loop through their own registers.
// An end-of-stream item stalls the input while up to H flush results go out.
// Reset clears the sums, counters, pipeline and emitter and restores the
// registers to H = 32 and 1/65 in Q0.24; the ring is not cleared.
// ----------------------------------------------------------------------------
module centered_moving_average_detrend_core
   import cmad_pkg::*;
#(
   parameter int MAX_HALF_WINDOW = 63,
   parameter int SAMPLE_BITS     = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // Fields from bit 0 up: sample_a, sample_b, zero padding.
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // Fields from bit 0 up: detrended_a, detrended_b, zero padding.
   output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata,
   // Fields from bit 0 up: has_window.
   output logic                   rsp_tuser,
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  csr_index_type          csr_index,
   input  logic [INV_BITS-1:0]    csr_data
);

   localparam int SUM_BITS  = SAMPLE_BITS + $clog2(2*MAX_HALF_WINDOW+1);
   localparam int PROD_BITS = SUM_BITS + INV_BITS + 1;
   localparam int DIFF_BITS = SUM_BITS + 2;
   localparam int ENT_BITS  = 2*SAMPLE_BITS;
   localparam logic [HW_BITS-1:0] MAX_H = HW_BITS'(MAX_HALF_WINDOW);

   logic [HW_BITS-1:0]   half_window_ff;
   logic [INV_BITS-1:0]  inv_window_len_ff;
   logic [SEEN_BITS-1:0] seen_ff;
   logic [SEEN_BITS-1:0] seen_in;
   logic [RING_AW-1:0]   wp_ff;
   logic [RING_AW-1:0]   wp_in;

   logic [ENT_BITS-1:0]  ring [RING_DEPTH];
   logic [ENT_BITS-1:0]  old_ff;
   logic [ENT_BITS-1:0]  ctr_ff;

   logic                 advance;
   logic                 accept;
   logic [HW_BITS-1:0]   h_eff;
   logic [RING_AW-1:0]   len;
   logic [RING_AW-1:0]   addr_old;
   logic [RING_AW-1:0]   addr_ctr;
   ctl_type              ctl_in;
   logic [SAMPLE_BITS-1:0] in_a;
   logic [SAMPLE_BITS-1:0] in_b;

   logic                 p1_valid_ff;
   ctl_type              p1_ctl_ff;
   logic [SAMPLE_BITS-1:0] p1_a_ff;
   logic [SAMPLE_BITS-1:0] p1_b_ff;

   logic signed [SUM_BITS-1:0] sum_a_ff;
   logic signed [SUM_BITS-1:0] sum_b_ff;
   logic signed [SUM_BITS-1:0] sum_a_in;
   logic signed [SUM_BITS-1:0] sum_b_in;

   logic                 p2_valid_ff;
   ctl_type              p2_ctl_ff;
   logic signed [SUM_BITS-1:0] p2_sum_a_ff;
   logic signed [SUM_BITS-1:0] p2_sum_b_ff;
   logic [ENT_BITS-1:0]  p2_ctr_ff;

   logic                 p3_valid_ff;
   ctl_type              p3_ctl_ff;
   logic signed [PROD_BITS-1:0] p3_prod_a_ff;
   logic signed [PROD_BITS-1:0] p3_prod_b_ff;
   logic signed [PROD_BITS-1:0] prod_a_in;
   logic signed [PROD_BITS-1:0] prod_b_in;
   logic [ENT_BITS-1:0]  p3_ctr_ff;

   logic [SAMPLE_BITS-1:0] det_a;
   logic [SAMPLE_BITS-1:0] det_b;
   logic                 emit_load;
   logic                 emit_free;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_window_ff    <= HW_BITS'(32);
         inv_window_len_ff <= INV_BITS'(258111);
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_HALF_WINDOW:    half_window_ff    <= csr_data[HW_BITS-1:0];
            CSR_INV_WINDOW_LEN: inv_window_len_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Input stage: window bookkeeping and ring addressing.
   assign advance    = emit_free;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;
   assign in_a       = req_tdata[SAMPLE_BITS-1:0];
   assign in_b       = req_tdata[ENT_BITS-1:SAMPLE_BITS];

   always_comb begin
      if (half_window_ff == '0) begin
         h_eff = HW_BITS'(1);
      end else if (half_window_ff > MAX_H) begin
         h_eff = MAX_H;
      end else begin
         h_eff = half_window_ff;
      end
      len      = {h_eff, 1'b1};
      addr_old = wp_ff - len;
      addr_ctr = wp_ff - RING_AW'(h_eff);

      ctl_in.sub_old    = seen_ff >= SEEN_BITS'(len);
      ctl_in.has_result = seen_ff >= SEEN_BITS'(h_eff);
      ctl_in.has_window = seen_ff >= SEEN_BITS'({h_eff, 1'b0});
      ctl_in.eos        = req_tlast;
      ctl_in.pending    = (seen_ff < SEEN_BITS'(h_eff)) ?
                          (seen_ff[HW_BITS-1:0] + HW_BITS'(1)) : h_eff;

      if (req_tlast) begin
         seen_in = '0;
         wp_in   = '0;
      end else begin
         seen_in = (seen_ff == SEEN_BITS'(SEEN_MAX)) ? seen_ff : seen_ff + SEEN_BITS'(1);
         wp_in   = wp_ff + RING_AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         wp_ff   <= '0;
      end else if (accept) begin
         seen_ff <= seen_in;
         wp_ff   <= wp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ring[wp_ff] <= {in_b, in_a};
      end
      if (advance) begin
         old_ff <= ring[addr_old];
         ctr_ff <= ring[addr_ctr];
      end
   end

   // Stage 1: running sums.
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_ctl_ff <= ctl_in;
         p1_a_ff   <= in_a;
         p1_b_ff   <= in_b;
      end
   end

   always_comb begin
      sum_a_in = sum_a_ff + SUM_BITS'($signed(p1_a_ff));
      sum_b_in = sum_b_ff + SUM_BITS'($signed(p1_b_ff));
      if (p1_ctl_ff.sub_old) begin
         sum_a_in = sum_a_in - SUM_BITS'($signed(old_ff[SAMPLE_BITS-1:0]));
         sum_b_in = sum_b_in - SUM_BITS'($signed(old_ff[ENT_BITS-1:SAMPLE_BITS]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_a_ff <= '0;
         sum_b_ff <= '0;
      end else if (advance && p1_valid_ff) begin
         sum_a_ff <= p1_ctl_ff.eos ? '0 : sum_a_in;
         sum_b_ff <= p1_ctl_ff.eos ? '0 : sum_b_in;
      end
   end

   // Stage 2: mean products.
   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (advance) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p2_ctl_ff   <= p1_ctl_ff;
         p2_sum_a_ff <= sum_a_in;
         p2_sum_b_ff <= sum_b_in;
         p2_ctr_ff   <= ctr_ff;
      end
   end

   assign prod_a_in = p2_sum_a_ff * $signed({1'b0, inv_window_len_ff});
   assign prod_b_in = p2_sum_b_ff * $signed({1'b0, inv_window_len_ff});

   // Stage 3: subtract the mean from the center sample and saturate.
   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (advance) begin
         p3_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p3_ctl_ff    <= p2_ctl_ff;
         p3_prod_a_ff <= prod_a_in;
         p3_prod_b_ff <= prod_b_in;
         p3_ctr_ff    <= p2_ctr_ff;
      end
   end

   function automatic logic [SAMPLE_BITS-1:0] detrend(
      input logic [SAMPLE_BITS-1:0] center,
      input logic [PROD_BITS-1:0]   prod
   );
      logic [SUM_BITS:0]    mean;
      logic [DIFF_BITS-1:0] diff;
      logic [DIFF_BITS-SAMPLE_BITS:0] top;
      mean = prod[PROD_BITS-1:INV_BITS];
      diff = {{(DIFF_BITS-SAMPLE_BITS){center[SAMPLE_BITS-1]}}, center}
             - {mean[SUM_BITS], mean};
      top  = diff[DIFF_BITS-1:SAMPLE_BITS-1];
      if ((&top) || !(|top)) begin
         return diff[SAMPLE_BITS-1:0];
      end else if (diff[DIFF_BITS-1]) begin
         return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   endfunction

   assign det_a     = detrend(p3_ctr_ff[SAMPLE_BITS-1:0], p3_prod_a_ff);
   assign det_b     = detrend(p3_ctr_ff[ENT_BITS-1:SAMPLE_BITS], p3_prod_b_ff);
   assign emit_load = advance && p3_valid_ff &&
                      (p3_ctl_ff.has_result || p3_ctl_ff.eos);

   cmad_emit #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .load       (emit_load),
      .load_ctl   (p3_ctl_ff),
      .load_a     (det_a),
      .load_b     (det_b),
      .free       (emit_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_pointer_tracks_count: assert property (@(posedge clock) disable iff (reset)
      (seen_ff != SEEN_BITS'(SEEN_MAX)) |-> (wp_ff == seen_ff[RING_AW-1:0]))
      else $error("ring write pointer out of step with sample count");

   a_sums_cleared: assert property (@(posedge clock) disable iff (reset)
      (advance && p1_valid_ff && p1_ctl_ff.eos) |=> ((sum_a_ff == '0) && (sum_b_ff == '0)))
      else $error("running sums not cleared after end of stream");

   a_window_needs_result: assert property (@(posedge clock) disable iff (reset)
      p3_valid_ff |-> (!p3_ctl_ff.has_window || p3_ctl_ff.has_result))
      else $error("full window marked on an item without a result");

endmodule

// ===== bench/centered_moving_average_detrend_core_tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for the centered moving average detrend core
// A queue of sample items feeds a clocked driver, and a clocked monitor
// predicts every result from its own copy of the window state and checks
// each result field by field. Short directed streams come first, then
// random streams under random window settings, a stream at the largest
// window that ends with the longest flush, and a stream with a long output
// stall.
// ----------------------------------------------------------------------------
module centered_moving_average_detrend_core_tb
   import cmad_pkg::*;
();

   localparam int SAMPLE_BITS = 24;
   localparam int DATA_BITS   = ((2*SAMPLE_BITS+7)/8)*8;
   localparam int MAX_HW      = 63;
   localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] a;
      logic signed [SAMPLE_BITS-1:0] b;
      logic                          eos;
   } sample_item_type;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] a;
      logic signed [SAMPLE_BITS-1:0] b;
      logic                          has_window;
      logic                          last;
   } detrend_out_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [DATA_BITS-1:0] req_tdata  = '0;
   logic                 req_tlast  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [DATA_BITS-1:0] rsp_tdata;
   logic                 rsp_tuser;
   logic                 rsp_tlast;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   csr_index_type        csr_index  = CSR_HALF_WINDOW;
   logic [INV_BITS-1:0]  csr_data   = '0;

   sample_item_type sample_q[$];
   detrend_out_type detrend_expected[$];
   int           queued_cnt   = 0;
   int           accepted_cnt = 0;
   int           fail_count   = 0;
   bit           calm         = 1'b0;
   bit           hold_req     = 1'b0;
   bit           hold_done    = 1'b0;
   int           hold_left    = 0;

   logic [HW_BITS-1:0] half_win;
   longint             inv_len;
   longint             ring_a [RING_DEPTH];
   longint             ring_b [RING_DEPTH];
   longint             sum_a;
   longint             sum_b;
   int                 seen;
   logic [RING_AW-1:0] wptr;

   centered_moving_average_detrend_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(longint v);
      if (v > longint'(S_MAX))
         return S_MAX;
      if (v < longint'(S_MIN))
         return S_MIN;
      return v[SAMPLE_BITS-1:0];
   endfunction

   function automatic void push_result(logic signed [SAMPLE_BITS-1:0] a,
                                       logic signed [SAMPLE_BITS-1:0] b,
                                       logic has_window, logic last);
      detrend_out_type r;
      r.a = a;
      r.b = b;
      r.has_window = has_window;
      r.last = last;
      detrend_expected.insert(detrend_expected.size(), r);
   endfunction

   function automatic void clear_stream();
      sum_a = 0;
      sum_b = 0;
      seen = 0;
      wptr = '0;
   endfunction

   // The result for the center H items back is produced as each item arrives.
   function automatic void predict_detrend(logic signed [SAMPLE_BITS-1:0] a,
                                           logic signed [SAMPLE_BITS-1:0] b,
                                           logic eos);
      int                 h;
      int                 len;
      int                 n;
      int                 pending;
      logic [RING_AW-1:0] idx;
      longint             mean_a;
      longint             mean_b;
      h = int'(half_win);
      if (h < 1)
         h = 1;
      if (h > MAX_HW)
         h = MAX_HW;
      len = 2*h + 1;
      n = seen;
      sum_a += longint'(a);
      sum_b += longint'(b);
      if (n >= len) begin
         idx = wptr - RING_AW'(len);
         sum_a -= ring_a[idx];
         sum_b -= ring_b[idx];
      end
      ring_a[wptr] = longint'(a);
      ring_b[wptr] = longint'(b);
      if (n >= h) begin
         if (n >= 2*h) begin
            idx = wptr - RING_AW'(h);
            mean_a = (sum_a * inv_len) >>> 24;
            mean_b = (sum_b * inv_len) >>> 24;
            push_result(clamp_sample(ring_a[idx] - mean_a),
                        clamp_sample(ring_b[idx] - mean_b), 1'b1, 1'b0);
         end else begin
            push_result('0, '0, 1'b0, 1'b0);
         end
      end
      wptr = wptr + 1'b1;
      if (seen < SEEN_MAX)
         seen++;
      if (eos) begin
         pending = (n + 1 < h) ? n + 1 : h;
         for (int i = 0; i < pending; i++)
            push_result('0, '0, 1'b0, i + 1 == pending);
         clear_stream();
      end
   endfunction

   always @(posedge clock) begin
      sample_item_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (sample_q.size() != 0 && (calm || $urandom_range(99) >= 35)) begin
            nxt = sample_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {nxt.b, nxt.a};
            req_tlast <= nxt.eos;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (hold_req && !hold_done) begin
         hold_done = 1'b1;
         hold_left = 300;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 35);
      end
   end

   always @(posedge clock) begin
      detrend_out_type want;
      logic signed [SAMPLE_BITS-1:0] got_a;
      logic signed [SAMPLE_BITS-1:0] got_b;
      if (reset) begin
         half_win = 6'd32;
         inv_len = 258111;
         clear_stream();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_HALF_WINDOW)
               half_win = csr_data[HW_BITS-1:0];
            else
               inv_len = longint'(csr_data);
         end
         if (req_tvalid && req_tready) begin
            predict_detrend(req_tdata[SAMPLE_BITS-1:0],
                            req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS], req_tlast);
            accepted_cnt++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got_a = rsp_tdata[SAMPLE_BITS-1:0];
            got_b = rsp_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            if (detrend_expected.size() == 0) begin
               $error("result with none expected: a %0d b %0d", got_a, got_b);
               fail_count++;
            end else begin
               want = detrend_expected.pop_front();
               if (got_a !== want.a) begin
                  $error("detrended_a: expected %0d, got %0d", want.a, got_a);
                  fail_count++;
               end
               if (got_b !== want.b) begin
                  $error("detrended_b: expected %0d, got %0d", want.b, got_b);
                  fail_count++;
               end
               if (rsp_tuser !== want.has_window) begin
                  $error("has_window: expected %0b, got %0b", want.has_window, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last_result: expected %0b, got %0b", want.last, rsp_tlast);
                  fail_count++;
               end
            end
         end
      end
   end

   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      logic signed [SAMPLE_BITS-1:0] v;
      case ($urandom_range(0, 9))
         0: v = S_MAX;
         1: v = S_MIN;
         2: v = '0;
         3: v = SAMPLE_BITS'($urandom_range(0, 255)) - SAMPLE_BITS'(128);
         default: v = SAMPLE_BITS'($urandom());
      endcase
      return v;
   endfunction

   task automatic queue_item(logic signed [SAMPLE_BITS-1:0] a,
                             logic signed [SAMPLE_BITS-1:0] b, logic eos);
      sample_item_type it;
      it.a = a;
      it.b = b;
      it.eos = eos;
      sample_q.insert(sample_q.size(), it);
      queued_cnt++;
   endtask

   task automatic queue_stream(int n, bit close);
      for (int i = 0; i < n; i++)
         queue_item(pick_sample(), pick_sample(), close && i == n - 1);
   endtask

   task automatic drain();
      do
         @(posedge clock);
      while (accepted_cnt != queued_cnt || detrend_expected.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [INV_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do
         @(posedge clock);
      while (!csr_ready);
   endtask

   task automatic set_window(int h, logic [INV_BITS-1:0] inv, logic [INV_BITS-1:0] junk);
      write_csr(CSR_HALF_WINDOW, {junk[INV_BITS-1:HW_BITS], HW_BITS'(h)});
      write_csr(CSR_INV_WINDOW_LEN, inv);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int h;
      int hh;
      int full;
      int len;
      int rand_items;
      logic [INV_BITS-1:0] inv;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // A stream shorter than the reset window gives only edge results.
      queue_item(S_MAX, S_MIN, 1'b0);
      queue_item(S_MIN, S_MAX, 1'b0);
      queue_item('1, '0, 1'b1);
      drain();

      // Smallest window: saturation both ways, floor of negative means,
      // and a stream of a single item.
      set_window(1, 24'(16777216 / 3), '1);
      queue_item(S_MAX, S_MIN, 1'b0);
      queue_item(S_MIN, S_MAX, 1'b0);
      queue_item(S_MAX, S_MIN, 1'b0);
      queue_item(S_MIN, S_MIN, 1'b0);
      queue_item(S_MIN, S_MIN, 1'b0);
      queue_item('1, SAMPLE_BITS'(1), 1'b0);
      queue_item(SAMPLE_BITS'(1), '1, 1'b0);
      queue_item('0, '0, 1'b1);
      queue_item(S_MAX, S_MAX, 1'b1);
      drain();

      // The half window changes in the middle of a stream.
      set_window(2, 24'(16777216 / 5), '0);
      queue_stream(6, 1'b0);
      drain();
      set_window(1, 24'(16777216 / 3), 24'($urandom()));
      queue_stream(6, 1'b1);
      drain();

      rand_items = 0;
      while (rand_items < 45) begin
         case ($urandom_range(0, 9))
            0: h = 0;
            1: h = 1;
            2, 3, 4, 5, 6, 7: h = $urandom_range(2, 6);
            default: h = $urandom_range(7, 12);
         endcase
         hh = (h == 0) ? 1 : h;
         full = 2*hh + 1;
         case ($urandom_range(0, 9))
            0: inv = '0;
            1: inv = '1;
            2: inv = 24'($urandom());
            default: inv = 24'(16777216 / full);
         endcase
         set_window(h, inv, 24'($urandom()));
         repeat ($urandom_range(1, 2)) begin
            if ($urandom_range(0, 4) == 0)
               len = $urandom_range(1, 2*hh);
            else
               len = $urandom_range(full, full + 4);
            queue_stream(len, 1'b1);
            rand_items += len;
         end
         if ($urandom_range(0, 4) == 0) begin
            len = $urandom_range(1, 2*hh + 6);
            queue_stream(len, 1'b0);
            rand_items += len;
         end
         drain();
      end

      // Largest window with no idling on either side; the last item
      // brings the most results one item can cause.
      calm = 1'b1;
      set_window(MAX_HW, 24'(16777216 / (2*MAX_HW + 1)), 24'($urandom()));
      queue_stream(MAX_HW + 1, 1'b1);
      drain();
      calm = 1'b0;

      // The output is held off for a long stretch while items keep coming.
      set_window(2, 24'(16777216 / 5), 24'($urandom()));
      hold_req = 1'b1;
      queue_stream(24, 1'b1);
      drain();
      repeat (12) @(posedge clock);

      if (fail_count == 0)
         $display("centered_moving_average_detrend_core_tb: clean");
      else
         $display("centered_moving_average_detrend_core_tb: errors");
      $finish;
   end

   initial begin
      #2000000;
      $display("centered_moving_average_detrend_core_tb: errors");
      $finish;
   end

endmodule
